@@ rtl/pac_pkg.sv @@
// Shared widths, states and divider selects for the polygon area and centroid block.
package pac_pkg;

	localparam int LAT_W       = 28;
	localparam int LON_W       = 29;
	localparam int HGT_W       = 32;
	localparam int AREA_W      = 64;
	localparam int PROD_W      = 2 * LON_W;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 160;

	localparam int IN_LAT_LO  = 0;
	localparam int IN_LON_LO  = IN_LAT_LO + LAT_W;
	localparam int IN_HGT_LO  = IN_LON_LO + LON_W;
	localparam int IN_USED_W  = IN_HGT_LO + HGT_W;

	localparam int OUT_CCW    = AREA_W;
	localparam int OUT_LAT_LO = OUT_CCW + 1;
	localparam int OUT_LON_LO = OUT_LAT_LO + LAT_W;
	localparam int OUT_HGT_LO = OUT_LON_LO + LON_W;
	localparam int OUT_USED_W = OUT_HGT_LO + HGT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} pac_state_t;

	typedef enum logic [1:0] {
		SEL_LAT,
		SEL_LON,
		SEL_HGT
	} div_sel_t;

endpackage

@@ rtl/pac_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
module pac_div #(
	parameter int DW = 40,
	parameter int NW = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic        [NW-1:0] divisor,
	output logic                 done,
	output logic signed [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [DW-1:0] quo_q;
	logic [NW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			quo_q <= dividend[DW-1] ? -dividend : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= NW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[NW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ rtl/polygon_area_centroid.sv @@
// Top level: streaming shoelace area, orientation and vertex centroid of a polygon.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------------------
//  s       | s_tvalid, s_tready | s_tdata: vertex lat, lon, height; s_tlast: last vertex
//  m       | m_tvalid, m_tready | m_tdata: area, ccw, centroid lat, lon, height; m_tuser: too_long
//
// A vertex is accepted, updates the sums, then uses the shared multiplier in MUL_A, MUL_B and
// MUL_C for the cross term; the first vertex of a polygon or a dropped one skips that step.
// The last vertex also runs the closing term through the multiplier, then three divisions on
// the one serial divider, and then the result is loaded into the output register.
// Reset clears the sequencer, the sums and the output valid flag; no clearing pass.
// A waiting result holds in the output register while the next polygon is taken; only the
// final load of the following result waits for it to go.
module polygon_area_centroid #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [27:0] vertex_lat, [56:28] vertex_lon, [88:57] vertex_height, [95:89] zero
	input  logic [pac_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [63:0] signed_area, [64] counter_clockwise, [92:65] centroid_lat,
	// [121:93] centroid_lon, [153:122] centroid_height, [159:154] zero
	output logic [pac_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [0] too_long
	output logic                               m_tuser
);

	import pac_pkg::*;

	localparam int SUM_EXT = $clog2(MAX_VERTICES);
	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int LSUM_W  = LAT_W + SUM_EXT;
	localparam int OSUM_W  = LON_W + SUM_EXT;
	localparam int HSUM_W  = HGT_W + SUM_EXT;
	localparam int DIV_W   = HSUM_W;

	pac_state_t state_q, state_d;
	div_sel_t   sel_q;

	logic signed [LAT_W-1:0]  cur_lat_q, first_lat_q, prev_lat_q, cent_lat_q;
	logic signed [LON_W-1:0]  cur_lon_q, first_lon_q, prev_lon_q, cent_lon_q;
	logic signed [HGT_W-1:0]  cur_hgt_q, cent_hgt_q;
	logic                     last_q;
	logic                     closing_q;
	logic                     overflow_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [AREA_W-1:0] twice_q;
	logic signed [LSUM_W-1:0] lat_sum_q;
	logic signed [OSUM_W-1:0] lon_sum_q;
	logic signed [HSUM_W-1:0] hgt_sum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic                     m_tuser_q;

	logic                     full;
	logic                     cross_needed;
	logic                     out_free;
	logic signed [LAT_W-1:0]  b_lat;
	logic signed [LON_W-1:0]  b_lon;
	logic signed [LON_W-1:0]  mul_x, mul_y;
	logic signed [PROD_W-1:0] product;
	logic signed [AREA_W-1:0] addend;
	logic [AREA_W-1:0]        area_half;
	logic                     ccw;
	logic                     div_start;
	logic                     div_done;
	logic signed [DIV_W-1:0]  div_dividend;
	logic signed [DIV_W-1:0]  div_quotient;

	assign full         = count_q >= CNT_W'(MAX_VERTICES);
	assign cross_needed = !full && (count_q != '0);
	assign out_free     = !m_tvalid_q || m_tready;

	assign b_lat   = closing_q ? first_lat_q : cur_lat_q;
	assign b_lon   = closing_q ? first_lon_q : cur_lon_q;
	assign mul_x   = (state_q == ST_MUL_A) ? prev_lon_q : LON_W'(prev_lat_q);
	assign mul_y   = (state_q == ST_MUL_A) ? LON_W'(b_lat) : b_lon;
	assign product = mul_x * mul_y;
	assign addend  = (state_q == ST_MUL_C) ? -AREA_W'(prod_q) : AREA_W'(prod_q);

	assign area_half = {twice_q[AREA_W-1], twice_q[AREA_W-1:1]};
	assign ccw       = !twice_q[AREA_W-1] && (twice_q[AREA_W-1:1] != '0);

	always_comb begin
		case (sel_q)
			SEL_LAT: div_dividend = DIV_W'(lat_sum_q);
			SEL_LON: div_dividend = DIV_W'(lon_sum_q);
			default: div_dividend = hgt_sum_q;
		endcase
	end

	pac_div #(
		.DW (DIV_W),
		.NW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (cross_needed || last_q) begin
					state_d = ST_MUL_A;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_MUL_C;
			ST_MUL_C: begin
				if (closing_q) begin
					state_d = ST_DIV_START;
				end else if (last_q) begin
					state_d = ST_MUL_A;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (sel_q == SEL_HGT) ? ST_EMIT : ST_DIV_START;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			closing_q  <= 1'b0;
			twice_q    <= '0;
			lat_sum_q  <= '0;
			lon_sum_q  <= '0;
			hgt_sum_q  <= '0;
			sel_q      <= SEL_LAT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					closing_q <= 1'b0;
				end
				ST_UPDATE: begin
					closing_q <= !cross_needed;
					sel_q     <= SEL_LAT;
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						count_q   <= count_q + 1'b1;
						lat_sum_q <= lat_sum_q + LSUM_W'(cur_lat_q);
						lon_sum_q <= lon_sum_q + OSUM_W'(cur_lon_q);
						hgt_sum_q <= hgt_sum_q + HSUM_W'(cur_hgt_q);
					end
				end
				ST_MUL_B, ST_MUL_C: begin
					twice_q <= twice_q + addend;
					if (state_q == ST_MUL_C && !closing_q && last_q) begin
						closing_q <= 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						case (sel_q)
							SEL_LAT: sel_q <= SEL_LON;
							SEL_LON: sel_q <= SEL_HGT;
							default: sel_q <= SEL_HGT;
						endcase
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						count_q    <= '0;
						overflow_q <= 1'b0;
						closing_q  <= 1'b0;
						twice_q    <= '0;
						lat_sum_q  <= '0;
						lon_sum_q  <= '0;
						hgt_sum_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cur_lat_q <= s_tdata[IN_LAT_LO +: LAT_W];
					cur_lon_q <= s_tdata[IN_LON_LO +: LON_W];
					cur_hgt_q <= s_tdata[IN_HGT_LO +: HGT_W];
					last_q    <= s_tlast;
				end
			end
			ST_UPDATE: begin
				if (!full && count_q == '0) begin
					first_lat_q <= cur_lat_q;
					first_lon_q <= cur_lon_q;
					prev_lat_q  <= cur_lat_q;
					prev_lon_q  <= cur_lon_q;
				end
			end
			ST_MUL_A, ST_MUL_B: begin
				prod_q <= product;
			end
			ST_MUL_C: begin
				if (!closing_q) begin
					prev_lat_q <= cur_lat_q;
					prev_lon_q <= cur_lon_q;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					case (sel_q)
						SEL_LAT: cent_lat_q <= div_quotient[LAT_W-1:0];
						SEL_LON: cent_lon_q <= div_quotient[LON_W-1:0];
						default: cent_hgt_q <= div_quotient[HGT_W-1:0];
					endcase
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= {(OUT_TDATA_W - OUT_USED_W)'(0), cent_hgt_q, cent_lon_q,
						cent_lat_q, ccw, area_half};
					m_tuser_q <= overflow_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/polygon_area_centroid_chk.sv @@
// Port-level checker for the polygon area and centroid block, bound to the top level.
module polygon_area_centroid_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pac_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	import pac_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	a_no_result_mid_polygon: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
		else $error("result raised by a vertex that is not last");

	a_ccw_matches_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_CCW] ==
			(!m_tdata[AREA_W-1] && (m_tdata[AREA_W-1:0] != '0))))
		else $error("orientation disagrees with area sign");

endmodule

bind polygon_area_centroid polygon_area_centroid_chk u_chk (.*);

@@ test/tb.sv @@
// Testbench for polygon_area_centroid: directed and random polygons checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import pac_pkg::*;

	localparam int VERTEX_LIMIT = 256;
	localparam int LAT_MAX      = 94371840;
	localparam int LON_MAX      = 188743680;

	typedef struct packed {
		logic signed [HGT_W-1:0] hgt;
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
	} vertex_t;

	typedef struct {
		logic [AREA_W-1:0] area;
		logic              ccw;
		logic [LAT_W-1:0]  clat;
		logic [LON_W-1:0]  clon;
		logic [HGT_W-1:0]  chgt;
		logic              too_long;
	} poly_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	bit                     idle_on;
	int                     mismatches;
	poly_result_t           pending_results[$];
	poly_result_t           oldest;

	logic signed [LAT_W-1:0] first_lat, prev_lat;
	logic signed [LON_W-1:0] first_lon, prev_lon;
	logic [AREA_W-1:0]       twice_area;
	longint                  lat_acc, lon_acc, hgt_acc;
	int                      open_count;
	bit                      seen_overflow;

	polygon_area_centroid #(
		.MAX_VERTICES(VERTEX_LIMIT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("polygon_area_centroid regression: fail");
		$finish;
	end

	function automatic logic [AREA_W-1:0] cross_term(logic signed [LAT_W-1:0] alat,
			logic signed [LON_W-1:0] alon, logic signed [LAT_W-1:0] blat,
			logic signed [LON_W-1:0] blon);
		longint t;
		t = longint'(alon) * longint'(blat) - longint'(alat) * longint'(blon);
		return t;
	endfunction

	function automatic void absorb_vertex(vertex_t v, bit last);
		logic [AREA_W-1:0] tw;
		longint            half;
		longint            n;
		longint            q;
		poly_result_t      r;
		if (open_count >= VERTEX_LIMIT) begin
			seen_overflow = 1'b1;
		end else begin
			if (open_count == 0) begin
				first_lat = v.lat;
				first_lon = v.lon;
			end else begin
				twice_area = twice_area + cross_term(prev_lat, prev_lon, v.lat, v.lon);
			end
			prev_lat = v.lat;
			prev_lon = v.lon;
			lat_acc  = lat_acc + $signed(v.lat);
			lon_acc  = lon_acc + $signed(v.lon);
			hgt_acc  = hgt_acc + $signed(v.hgt);
			open_count++;
		end
		if (last) begin
			tw         = twice_area + cross_term(prev_lat, prev_lon, first_lat, first_lon);
			half       = $signed(tw) >>> 1;
			n          = longint'(open_count);
			r.area     = half;
			r.ccw      = half > 0;
			q          = lat_acc / n;
			r.clat     = q[LAT_W-1:0];
			q          = lon_acc / n;
			r.clon     = q[LON_W-1:0];
			q          = hgt_acc / n;
			r.chgt     = q[HGT_W-1:0];
			r.too_long = seen_overflow;
			pending_results = {pending_results, r};
			twice_area    = '0;
			lat_acc       = 0;
			lon_acc       = 0;
			hgt_acc       = 0;
			open_count    = 0;
			seen_overflow = 1'b0;
		end
	endfunction

	function automatic vertex_t mk_vertex(int lat, int lon, int hgt);
		vertex_t v;
		v.lat = lat[LAT_W-1:0];
		v.lon = lon[LON_W-1:0];
		v.hgt = hgt;
		return v;
	endfunction

	function automatic vertex_t random_vertex();
		int unsigned pick;
		int          lat;
		int          lon;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			lat = int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
			lon = int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
		end else if (pick < 9) begin
			lat = $urandom;
			lon = $urandom;
		end else begin
			lat = $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
			lon = $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
		end
		return mk_vertex(lat, lon, $urandom);
	endfunction

	function automatic void compare_field(string name, logic [AREA_W-1:0] want,
			logic [AREA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_vertex(vertex_t v, bit last);
		logic [IN_TDATA_W-1:0] word;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		word                          = '0;
		word[IN_LAT_LO +: LAT_W]      = v.lat;
		word[IN_LON_LO +: LON_W]      = v.lon;
		word[IN_HGT_LO +: HGT_W]      = v.hgt;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		absorb_vertex(v, last);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_single_vertex();
		send_vertex(mk_vertex(LAT_MAX, LON_MAX, 32'h7fff_ffff), 1'b1);
		send_vertex(mk_vertex(-LAT_MAX, -LON_MAX, 32'h8000_0000), 1'b1);
		send_vertex(mk_vertex(0, 0, 0), 1'b1);
	endtask

	task automatic test_orientation();
		send_vertex(mk_vertex(0, 0, 1), 1'b0);
		send_vertex(mk_vertex(0, 10, 2), 1'b0);
		send_vertex(mk_vertex(10, 10, 3), 1'b0);
		send_vertex(mk_vertex(10, 0, 4), 1'b1);
		send_vertex(mk_vertex(10, 0, 4), 1'b0);
		send_vertex(mk_vertex(10, 10, 3), 1'b0);
		send_vertex(mk_vertex(0, 10, 2), 1'b0);
		send_vertex(mk_vertex(0, 0, 1), 1'b1);
		send_vertex(mk_vertex(-LAT_MAX, -LON_MAX, 32'h7fff_ffff), 1'b0);
		send_vertex(mk_vertex(-LAT_MAX, LON_MAX, 32'h7fff_ffff), 1'b0);
		send_vertex(mk_vertex(LAT_MAX, LON_MAX, 32'h7fff_ffff), 1'b0);
		send_vertex(mk_vertex(LAT_MAX, -LON_MAX, 32'h7fff_ffff), 1'b1);
		send_vertex(mk_vertex(5, 5, -9), 1'b0);
		send_vertex(mk_vertex(10, 10, 9), 1'b1);
	endtask

	task automatic test_rounding();
		send_vertex(mk_vertex(0, 0, -5), 1'b0);
		send_vertex(mk_vertex(1, 0, -5), 1'b0);
		send_vertex(mk_vertex(0, 1, -1), 1'b1);
		send_vertex(mk_vertex(-1, -3, -7), 1'b0);
		send_vertex(mk_vertex(0, 0, 0), 1'b1);
		send_vertex(mk_vertex(-134217728, -268435456, 32'h8000_0000), 1'b0);
		send_vertex(mk_vertex(134217727, 268435455, 32'h7fff_ffff), 1'b1);
	endtask

	task automatic test_vertex_limit();
		vertex_t corner[4];
		corner[0] = mk_vertex(-134217728, -268435456, 0);
		corner[1] = mk_vertex(-134217728, 268435455, 0);
		corner[2] = mk_vertex(134217727, 268435455, 0);
		corner[3] = mk_vertex(134217727, -268435456, 0);
		for (int k = 0; k < VERTEX_LIMIT; k++)
			send_vertex(random_vertex(), k == VERTEX_LIMIT - 1);
		// full-width square laps wrap the area sum; the last two vertices are dropped
		for (int k = 0; k < VERTEX_LIMIT + 2; k++) begin
			corner[k % 4].hgt = $urandom;
			send_vertex(corner[k % 4], k == VERTEX_LIMIT + 1);
		end
	endtask

	task automatic test_random_polygons(int n_items);
		int sent;
		int n_vert;
		sent = 0;
		while (sent < n_items) begin
			n_vert = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int k = 0; k < n_vert; k++)
				send_vertex(random_vertex(), k == n_vert - 1);
			sent += n_vert;
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expected result waiting");
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				compare_field("signed_area", oldest.area, m_tdata[AREA_W-1:0]);
				compare_field("counter_clockwise", AREA_W'(oldest.ccw),
					AREA_W'(m_tdata[OUT_CCW]));
				compare_field("centroid_lat", AREA_W'(oldest.clat),
					AREA_W'(m_tdata[OUT_LAT_LO +: LAT_W]));
				compare_field("centroid_lon", AREA_W'(oldest.clon),
					AREA_W'(m_tdata[OUT_LON_LO +: LON_W]));
				compare_field("centroid_height", AREA_W'(oldest.chgt),
					AREA_W'(m_tdata[OUT_HGT_LO +: HGT_W]));
				compare_field("too_long", AREA_W'(oldest.too_long), AREA_W'(m_tuser));
			end
		end
	end

	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		arst_n        = 1'b0;
		idle_on       = 1'b1;
		mismatches    = 0;
		twice_area    = '0;
		lat_acc       = 0;
		lon_acc       = 0;
		hgt_acc       = 0;
		open_count    = 0;
		seen_overflow = 1'b0;
		first_lat     = '0;
		first_lon     = '0;
		prev_lat      = '0;
		prev_lon      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_vertex();
		drain_results();
		test_orientation();
		drain_results();
		test_rounding();
		drain_results();
		test_vertex_limit();
		drain_results();
		test_random_polygons(70);
		drain_results();
		idle_on = 1'b0;
		test_random_polygons(40);
		drain_results();

		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("polygon_area_centroid regression: pass");
		else
			$display("polygon_area_centroid regression: fail");
		$finish;
	end

endmodule
